/* rtl/core/button_debounce_long_press_assert.svh */
// ----------------------------------------------------------------------------
// button debounce assertion macros
// concurrent assertion forms, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_ASSERT_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_ASSERT_SVH

// same-cycle implication
`define BDLP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bdlp assertion failed");

// next-cycle implication
`define BDLP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bdlp assertion failed");

`endif

/* rtl/core/bdlp_pkg.sv */
// ----------------------------------------------------------------------------
// bdlp_pkg
// shared types and constants of the button debouncer with long press
// ----------------------------------------------------------------------------
package bdlp_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned MsW = 16;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDataW = 16;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_ACTIVE_LOW = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_LONG_MODE = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_LONG_PRESS = 8'd3;

  // reset values
  localparam logic [MsW-1:0] DEBOUNCE_RST = 16'd10;
  localparam logic [MsW-1:0] LONG_PRESS_RST = 16'd1000;

  typedef struct packed {
    logic active_low;
    logic long_press_mode;
    logic [MsW-1:0] debounce_ms;
    logic [MsW-1:0] long_press_ms;
  } cfg_t;

  typedef struct packed {
    logic seen_active;
    logic [TimeW-1:0] change_stamp;
    logic button_down;
    logic long_fired;
  } state_t;

  typedef struct packed {
    logic pressed;
    logic long_press;
    logic clicked;
  } result_t;

endpackage

/* rtl/core/bdlp_cfg_regs.sv */
// ----------------------------------------------------------------------------
// bdlp_cfg_regs
// configuration register file, written through the cfg channel
// ----------------------------------------------------------------------------
module bdlp_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [bdlp_pkg::CfgIdxW-1:0]  wr_index,
  input  logic [bdlp_pkg::CfgDataW-1:0] wr_data,
  output bdlp_pkg::cfg_t                cfg
);

  bdlp_pkg::cfg_t cfg_r;
  bdlp_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        bdlp_pkg::REG_ACTIVE_LOW: cfg_nxt.active_low = wr_data[0];
        bdlp_pkg::REG_LONG_MODE:  cfg_nxt.long_press_mode = wr_data[0];
        bdlp_pkg::REG_DEBOUNCE:   cfg_nxt.debounce_ms = wr_data;
        bdlp_pkg::REG_LONG_PRESS: cfg_nxt.long_press_ms = wr_data;
        default: ; // unknown index, ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active_low <= 1'b0;
      cfg_r.long_press_mode <= 1'b0;
      cfg_r.debounce_ms <= bdlp_pkg::DEBOUNCE_RST;
      cfg_r.long_press_ms <= bdlp_pkg::LONG_PRESS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/core/bdlp_step.sv */
// ----------------------------------------------------------------------------
// bdlp_step
// combinational update of the debounce state for one poll
// ----------------------------------------------------------------------------
module bdlp_step (
  input  bdlp_pkg::cfg_t                cfg,
  input  bdlp_pkg::state_t              st,
  input  logic                          pin_level,
  input  logic [bdlp_pkg::TimeW-1:0]    now_ms,
  output bdlp_pkg::state_t              st_nxt,
  output bdlp_pkg::result_t             res
);

  // signed elapsed time beyond a 16-bit limit; negative never counts
  function automatic logic elapsed_over(input logic [bdlp_pkg::TimeW-1:0] diff,
                                        input logic [bdlp_pkg::MsW-1:0] limit);
    logic hi_set;
    hi_set = |diff[bdlp_pkg::TimeW-2:bdlp_pkg::MsW];
    return !diff[bdlp_pkg::TimeW-1] && (hi_set || (diff[bdlp_pkg::MsW-1:0] > limit));
  endfunction

  logic                       is_active;
  logic                       deb_over;
  logic [bdlp_pkg::TimeW-1:0] deb_diff;
  logic [bdlp_pkg::TimeW-1:0] lp_diff;
  logic                       click;
  bdlp_pkg::state_t           mid;

  assign is_active = (pin_level != cfg.active_low);
  assign deb_diff = now_ms - st.change_stamp;
  assign deb_over = elapsed_over(deb_diff, cfg.debounce_ms);

  // click rule
  always_comb begin
    mid = st;
    click = 1'b0;
    if (is_active && !st.button_down) begin
      if (!st.seen_active) begin
        mid.seen_active = 1'b1;
        mid.change_stamp = now_ms;
      end else if (deb_over) begin
        mid.change_stamp = now_ms;
        mid.button_down = 1'b1;
        mid.long_fired = 1'b0;
        click = !cfg.long_press_mode;
      end
    end else if (!is_active && st.button_down) begin
      if (st.seen_active) begin
        mid.seen_active = 1'b0;
        mid.change_stamp = now_ms;
      end else if (deb_over) begin
        mid.button_down = 1'b0;
        click = cfg.long_press_mode && !st.long_fired;
      end
    end
  end

  // long-press rule, measured from the updated stamp
  assign lp_diff = now_ms - mid.change_stamp;

  always_comb begin
    st_nxt = mid;
    res.clicked = click;
    res.long_press = 1'b0;
    if (mid.button_down && !mid.long_fired && elapsed_over(lp_diff, cfg.long_press_ms)) begin
      st_nxt.long_fired = 1'b1;
      res.long_press = 1'b1;
    end
    res.pressed = st_nxt.button_down;
  end

endmodule

/* rtl/core/button_debounce_long_press.sv */
// ----------------------------------------------------------------------------
// button_debounce_long_press
// push-button debouncer with optional long-press detection
// ----------------------------------------------------------------------------
// Each input word is one poll of the button pin with the current millisecond
// time, and each poll gives exactly one result word (clicked, long_press,
// pressed). A poll is taken into an input register, the debounce and
// long-press rules run as one short pass of subtract-and-compare logic
// against the state registers, and the result lands in an output register
// that drives out_tvalid and out_tdata. One poll can be accepted every
// cycle while the output side keeps up. A stalled output holds the
// pipeline; the input register still takes a word while its slot is free.
// Configuration writes are accepted at any time (cfg_ready is tied high)
// but should be made only while no poll is in flight. Register indexes:
// 0 active_low, 1 long_press_mode, 2 debounce_ms, 3 long_press_ms; other
// indexes are ignored.
// ----------------------------------------------------------------------------
module button_debounce_long_press (
  input  logic                          clk,
  input  logic                          rst_n,
  // poll input
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [39:0]                   in_tdata,   // [0] pin_level, [32:1] now_ms, rest zero
  // result output
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [7:0]                    out_tdata,  // [0] clicked, [1] long_press, [2] pressed
  // configuration write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bdlp_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [bdlp_pkg::CfgDataW-1:0] cfg_data
);

  bdlp_pkg::cfg_t    cfg;
  bdlp_pkg::state_t  st_r;
  bdlp_pkg::state_t  st_nxt;
  bdlp_pkg::result_t res;
  bdlp_pkg::result_t out_word_r;

  logic                       in_valid_r;
  logic                       in_level_r;
  logic [bdlp_pkg::TimeW-1:0] in_now_r;
  logic                       out_valid_r;
  logic                       advance;

  // register file
  assign cfg_ready = 1'b1;

  bdlp_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // pipeline moves when the output slot is empty or being drained
  assign advance = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_level_r <= in_tdata[0];
      in_now_r <= in_tdata[bdlp_pkg::TimeW:1];
    end
  end

  // one poll's worth of debounce logic
  bdlp_step u_step (
    .cfg       (cfg),
    .st        (st_r),
    .pin_level (in_level_r),
    .now_ms    (in_now_r),
    .st_nxt    (st_nxt),
    .res       (res)
  );

  // debounce state, committed as the poll moves to the output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.seen_active <= 1'b1;  // active level assumed at start
      st_r.change_stamp <= '0;
      st_r.button_down <= 1'b0;
      st_r.long_fired <= 1'b0;
    end else if (advance && in_valid_r) begin
      st_r <= st_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid_r) begin
      out_word_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {5'b0, out_word_r};

  `include "button_debounce_long_press_assert.svh"

  // a click and a long press never come from the same poll
  `BDLP_ASSERT_IMPL(a_click_lp_excl, out_valid_r, !(out_word_r.clicked && out_word_r.long_press))
  // a long press is only reported while the button is down
  `BDLP_ASSERT_IMPL(a_lp_pressed, out_valid_r && out_word_r.long_press, out_word_r.pressed)
  // a held poll is not dropped while the output is stalled
  `BDLP_ASSERT_NEXT(a_in_hold, in_valid_r && !advance, in_valid_r && $stable(in_now_r))
  // the state only changes when a poll is committed
  `BDLP_ASSERT_NEXT(a_state_hold, !(advance && in_valid_r), $stable(st_r))

endmodule
